@@ sv/uvsph_pkg.sv @@
// ----------------------------------------------------------------------------
// uvsph_pkg
// Shared types, constants and the quarter-wave sine table of the UV sphere
// grid point generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uvsph_pkg;

   localparam int TRIG_TABLE_DEPTH = 256;
   localparam int TAB_AW = $clog2(TRIG_TABLE_DEPTH + 1);
   localparam int MAX_DIVISIONS = 255;
   localparam int MIN_SECTORS = 3;
   localparam int MIN_STACKS = 2;
   localparam int CSR_IDX_W = 2;
   localparam int RECIP_W = 32;
   localparam int ONE_Q14 = 16384;

   localparam logic [CSR_IDX_W-1:0] REG_SECTOR_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STACK_COUNT = 2'd1;

   localparam logic [7:0] SECTOR_RESET = 8'd10;
   localparam logic [7:0] STACK_RESET = 8'd10;
   localparam logic [15:0] QUARTER_TURN = 16'h4000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Taylor series denominators (2n)(2n+1) for n = 1..6
   localparam int TAYLOR_DIV [1:6] = '{6, 20, 42, 72, 110, 156};

   typedef logic [14:0] sin_tab_type [0:TRIG_TABLE_DEPTH];

   typedef struct packed {
      logic [14:0] tex_s;
      logic [14:0] tex_t;
      logic [15:0] vertex_index;
      logic [15:0] below_index;
      logic        upper_tri_valid;
      logic        lower_tri_valid;
      logic        item_valid;
   } mesh_info_type;

   typedef struct packed {
      mesh_info_type info;
      logic [15:0]   vph;
      logic [15:0]   uph;
   } phase_word_type;

   typedef struct packed {
      mesh_info_type      info;
      logic signed [15:0] sin_u;
      logic signed [15:0] cos_u;
      logic signed [15:0] sin_v;
      logic signed [15:0] cos_v;
   } trig_word_type;

   typedef struct packed {
      mesh_info_type      info;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
   } point_word_type;

   typedef struct packed {
      logic               busy;
      logic [RECIP_W-1:0] value;
   } recip_status_type;

   // Q30 Taylor series of sin, rounded to Q14; evaluated at elaboration
   function automatic sin_tab_type build_sin_tab();
      sin_tab_type        tab;
      logic [63:0]        x;
      logic [63:0]        term;
      logic [63:0]        q;
      logic signed [63:0] acc;
      for (int e = 0; e <= TRIG_TABLE_DEPTH; e++) begin
         x = (64'(e) * HALF_PI_Q30) / 64'(TRIG_TABLE_DEPTH);
         term = x;
         acc = $signed(x);
         for (int n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'(TAYLOR_DIV[n]);
            if ((n & 1) != 0) begin
               acc = acc - $signed(term);
            end else begin
               acc = acc + $signed(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         q = (64'(acc) + 64'd32768) >> 16;
         if (q > 64'(ONE_Q14)) begin
            q = 64'(ONE_Q14);
         end
         tab[e] = q[14:0];
      end
      return tab;
   endfunction

   localparam sin_tab_type SIN_TAB = build_sin_tab();

   // sine of a 16-bit phase through the quarter-wave table, Q1.14
   function automatic logic signed [15:0] sin_phase(input logic [15:0] p);
      logic [1:0]          quad;
      logic [13:0]         r;
      logic [TAB_AW+14:0]  scaled;
      logic [TAB_AW-1:0]   idx;
      logic [TAB_AW-1:0]   sel;
      logic [15:0]         mag;
      quad = p[15:14];
      r = p[13:0];
      scaled = (TAB_AW+15)'(r) * (TAB_AW+15)'(TRIG_TABLE_DEPTH) + (TAB_AW+15)'(8192);
      idx = scaled[TAB_AW+13:14];
      sel = quad[0] ? (TAB_AW'(TRIG_TABLE_DEPTH) - idx) : idx;
      mag = {1'b0, SIN_TAB[sel]};
      return quad[1] ? (16'd0 - mag) : mag;
   endfunction

endpackage

@@ sv/uv_sphere_mesh_point.sv @@
// ----------------------------------------------------------------------------
// uv_sphere_mesh_point
// Pipeline: four register stages from an accepted req word to rsp_valid:
//   reciprocal multiply, sine table, product, rounding/output.
// Throughput: one word per cycle while no reciprocal runs; stalls back up
//   stage by stage, bubbles close. Reset (synchronous) sets both counts
//   to 10; after reset and each count write a serial reciprocal run holds req_ready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uv_sphere_mesh_point (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_stack_idx,
   input  logic [7:0]                      req_sector_idx,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [15:0]              rsp_pos_x,
   output logic signed [15:0]              rsp_pos_y,
   output logic signed [15:0]              rsp_pos_z,
   output logic [14:0]                     rsp_tex_s,
   output logic [14:0]                     rsp_tex_t,
   output logic [15:0]                     rsp_vertex_index,
   output logic [15:0]                     rsp_below_index,
   output logic                            rsp_upper_tri_valid,
   output logic                            rsp_lower_tri_valid,
   output logic                            rsp_item_valid,

   input  logic                            csr_we,
   input  logic [uvsph_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                      csr_wdata
);

   logic [7:0]                  sector_count_ff, sector_count_in;
   logic [7:0]                  stack_count_ff, stack_count_in;
   logic                        sector_start, stack_start;
   uvsph_pkg::recip_status_type sector_recip, stack_recip;
   logic                        busy;

   logic                        en_front, en_trig, en_mul, en_out;
   logic                        front_valid, trig_valid, mul_valid, out_valid;
   uvsph_pkg::phase_word_type   front_word;
   uvsph_pkg::trig_word_type    trig_word;
   uvsph_pkg::point_word_type   out_word;

   function automatic logic [7:0] clamp_count(input logic [7:0] v, input logic [7:0] lo);
      if (v < lo) begin
         return lo;
      end else if (v > 8'(uvsph_pkg::MAX_DIVISIONS)) begin
         return 8'(uvsph_pkg::MAX_DIVISIONS);
      end
      return v;
   endfunction

   // ---- count registers ----
   always_comb begin
      sector_count_in = sector_count_ff;
      stack_count_in = stack_count_ff;
      sector_start = 1'b0;
      stack_start = 1'b0;
      if (csr_we) begin
         case (csr_index)
            uvsph_pkg::REG_SECTOR_COUNT: begin
               sector_count_in = clamp_count(csr_wdata, 8'(uvsph_pkg::MIN_SECTORS));
               sector_start = 1'b1;
            end
            uvsph_pkg::REG_STACK_COUNT: begin
               stack_count_in = clamp_count(csr_wdata, 8'(uvsph_pkg::MIN_STACKS));
               stack_start = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_count_ff <= uvsph_pkg::SECTOR_RESET;
         stack_count_ff <= uvsph_pkg::STACK_RESET;
      end else begin
         sector_count_ff <= sector_count_in;
         stack_count_ff <= stack_count_in;
      end
   end

   uvsph_recip u_recip_sector (
      .clock   (clock),
      .reset   (reset),
      .start   (sector_start),
      .divisor (sector_count_ff),
      .status  (sector_recip)
   );

   uvsph_recip u_recip_stack (
      .clock   (clock),
      .reset   (reset),
      .start   (stack_start),
      .divisor (stack_count_ff),
      .status  (stack_recip)
   );

   assign busy = sector_recip.busy | stack_recip.busy;

   // ---- pipeline flow control: a stage loads when empty or draining ----
   assign en_out = ~out_valid | rsp_ready;
   assign en_mul = ~mul_valid | en_out;
   assign en_trig = ~trig_valid | en_mul;
   assign en_front = ~front_valid | en_trig;
   assign req_ready = en_front & ~busy;

   uvsph_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en_front),
      .in_valid     (req_valid & ~busy),
      .stack_idx    (req_stack_idx),
      .sector_idx   (req_sector_idx),
      .sector_count (sector_count_ff),
      .stack_count  (stack_count_ff),
      .recip_s      (sector_recip.value),
      .recip_t      (stack_recip.value),
      .out_valid    (front_valid),
      .out_word     (front_word)
   );

   uvsph_trig u_trig (
      .clock     (clock),
      .reset     (reset),
      .en        (en_trig),
      .in_valid  (front_valid),
      .in_word   (front_word),
      .out_valid (trig_valid),
      .out_word  (trig_word)
   );

   uvsph_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en_mul    (en_mul),
      .en_out    (en_out),
      .in_valid  (trig_valid),
      .in_word   (trig_word),
      .mul_valid (mul_valid),
      .out_valid (out_valid),
      .out_word  (out_word)
   );

   assign rsp_valid = out_valid;
   assign rsp_pos_x = out_word.pos_x;
   assign rsp_pos_y = out_word.pos_y;
   assign rsp_pos_z = out_word.pos_z;
   assign rsp_tex_s = out_word.info.tex_s;
   assign rsp_tex_t = out_word.info.tex_t;
   assign rsp_vertex_index = out_word.info.vertex_index;
   assign rsp_below_index = out_word.info.below_index;
   assign rsp_upper_tri_valid = out_word.info.upper_tri_valid;
   assign rsp_lower_tri_valid = out_word.info.lower_tri_valid;
   assign rsp_item_valid = out_word.info.item_valid;

`ifndef SYNTH
   // no word enters while a reciprocal is being rebuilt
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !(req_valid && req_ready))
      else $error("word accepted while reciprocal unit busy");

   // out-of-range words carry all-zero payload
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item_valid) |->
         (rsp_pos_x == 16'sd0 && rsp_pos_y == 16'sd0 && rsp_pos_z == 16'sd0
          && rsp_tex_s == 15'd0 && rsp_tex_t == 15'd0
          && rsp_vertex_index == 16'd0 && rsp_below_index == 16'd0))
      else $error("invalid word has nonzero payload");

   a_flags_need_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_upper_tri_valid || rsp_lower_tri_valid)) |-> rsp_item_valid)
      else $error("triangle flag set on invalid word");

   a_below_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_valid) |->
         (rsp_below_index == rsp_vertex_index + 16'(sector_count_ff) + 16'd1))
      else $error("below index does not follow vertex index");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pos_z <= 16'sd16384 && rsp_pos_z >= -16'sd16384
                     && rsp_pos_x <= 16'sd16384 && rsp_pos_x >= -16'sd16384))
      else $error("position out of unit range");
`endif

endmodule

@@ sv/uvsph_recip.sv @@
// ----------------------------------------------------------------------------
// uvsph_recip
// Bit-serial reciprocal unit: value = ceil(2^32 / divisor), one quotient bit
// per cycle. Runs after reset and after each start pulse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvsph_recip (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [7:0]                  divisor,
   output uvsph_pkg::recip_status_type status
);

   localparam int STEP_W = $clog2(uvsph_pkg::RECIP_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(uvsph_pkg::RECIP_W - 1);

   logic                              run_ff, run_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic [7:0]                        rem_ff, rem_in;
   logic [uvsph_pkg::RECIP_W-1:0]     quo_ff, quo_in;
   logic [uvsph_pkg::RECIP_W-1:0]     value_ff, value_in;
   logic [8:0]                        shifted;
   logic                              fits;

   // numerator is 2^32-1, so every bit shifted in is a one
   always_comb begin
      shifted = {rem_ff, 1'b1};
      fits = (shifted >= {1'b0, divisor});
      run_in = run_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      value_in = value_ff;
      if (start) begin
         run_in = 1'b1;
         step_in = '0;
         rem_in = '0;
         quo_in = '0;
      end else if (run_ff) begin
         rem_in = fits ? 8'(shifted - {1'b0, divisor}) : shifted[7:0];
         quo_in = {quo_ff[uvsph_pkg::RECIP_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in = 1'b0;
            value_in = quo_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b1;
         step_ff <= '0;
         rem_ff <= '0;
         quo_ff <= '0;
      end else begin
         run_ff <= run_in;
         step_ff <= step_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign status.busy = run_ff;
   assign status.value = value_ff;

endmodule

@@ sv/uvsph_front.sv @@
// ----------------------------------------------------------------------------
// uvsph_front
// First stage: quotients by reciprocal multiply (phases, texture coords),
// vertex indices, triangle flags and range check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvsph_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [7:0]                    stack_idx,
   input  logic [7:0]                    sector_idx,
   input  logic [7:0]                    sector_count,
   input  logic [7:0]                    stack_count,
   input  logic [uvsph_pkg::RECIP_W-1:0] recip_s,
   input  logic [uvsph_pkg::RECIP_W-1:0] recip_t,
   output logic                          out_valid,
   output uvsph_pkg::phase_word_type     out_word
);

   localparam int PW = 24 + uvsph_pkg::RECIP_W;

   logic                       valid_ff;
   uvsph_pkg::phase_word_type  word_ff, word_in;
   logic [23:0]                num_v, num_s, num_u, num_t;
   logic [PW-1:0]              prod_v, prod_s, prod_u, prod_t;
   logic [15:0]                k1, k2;
   logic                       in_range;

   always_comb begin
      // n*scale + count/2 is a concatenation since count/2 < scale
      num_v = {sector_idx, 9'd0, sector_count[7:1]};
      num_s = {2'd0, sector_idx, 7'd0, sector_count[7:1]};
      num_u = {1'b0, stack_idx, 8'd0, stack_count[7:1]};
      num_t = {2'd0, stack_idx, 7'd0, stack_count[7:1]};
      prod_v = PW'(num_v) * PW'(recip_s);
      prod_s = PW'(num_s) * PW'(recip_s);
      prod_u = PW'(num_u) * PW'(recip_t);
      prod_t = PW'(num_t) * PW'(recip_t);

      k1 = 16'(stack_idx) * (16'(sector_count) + 16'd1) + 16'(sector_idx);
      k2 = k1 + 16'(sector_count) + 16'd1;
      in_range = (stack_idx <= stack_count) && (sector_idx <= sector_count);

      word_in = '0;
      word_in.vph = prod_v[uvsph_pkg::RECIP_W+15:uvsph_pkg::RECIP_W];
      word_in.uph = uvsph_pkg::QUARTER_TURN
                    - prod_u[uvsph_pkg::RECIP_W+15:uvsph_pkg::RECIP_W];
      word_in.info.item_valid = in_range;
      if (in_range) begin
         word_in.info.tex_s = prod_s[uvsph_pkg::RECIP_W+14:uvsph_pkg::RECIP_W];
         word_in.info.tex_t = prod_t[uvsph_pkg::RECIP_W+14:uvsph_pkg::RECIP_W];
         word_in.info.vertex_index = k1;
         word_in.info.below_index = k2;
         word_in.info.upper_tri_valid = (sector_idx < sector_count)
                                        && (stack_idx < stack_count)
                                        && (stack_idx != 8'd0);
         word_in.info.lower_tri_valid = (sector_idx < sector_count)
                                        && ((9'(stack_idx) + 9'd1) < 9'(stack_count));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word = word_ff;

endmodule

@@ sv/uvsph_trig.sv @@
// ----------------------------------------------------------------------------
// uvsph_trig
// Second stage: sine and cosine of the stack and sector phases from the
// quarter-wave table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvsph_trig (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  uvsph_pkg::phase_word_type in_word,
   output logic                      out_valid,
   output uvsph_pkg::trig_word_type  out_word
);

   logic                      valid_ff;
   uvsph_pkg::trig_word_type  word_ff, word_in;

   always_comb begin
      word_in.info = in_word.info;
      word_in.sin_u = uvsph_pkg::sin_phase(in_word.uph);
      word_in.cos_u = uvsph_pkg::sin_phase(in_word.uph + uvsph_pkg::QUARTER_TURN);
      word_in.sin_v = uvsph_pkg::sin_phase(in_word.vph);
      word_in.cos_v = uvsph_pkg::sin_phase(in_word.vph + uvsph_pkg::QUARTER_TURN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word = word_ff;

endmodule

@@ sv/uvsph_scale.sv @@
// ----------------------------------------------------------------------------
// uvsph_scale
// Third and fourth stages: cos(u)*cos(v) and cos(u)*sin(v) products, then
// rounding back to Q1.14 into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvsph_scale (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en_mul,
   input  logic                      en_out,
   input  logic                      in_valid,
   input  uvsph_pkg::trig_word_type  in_word,
   output logic                      mul_valid,
   output logic                      out_valid,
   output uvsph_pkg::point_word_type out_word
);

   typedef struct packed {
      uvsph_pkg::mesh_info_type info;
      logic signed [31:0]       prod_x;
      logic signed [31:0]       prod_y;
      logic signed [15:0]       pos_z;
   } mul_word_type;

   logic                       mul_valid_ff;
   logic                       out_valid_ff;
   mul_word_type               mul_ff, mul_in;
   uvsph_pkg::point_word_type  out_ff, out_in;

   // Q28 -> Q14, half away from zero
   function automatic logic [15:0] round_q14(input logic signed [31:0] prod);
      logic [31:0] mag;
      logic [31:0] res;
      mag = prod[31] ? (32'd0 - prod) : prod;
      res = (mag + 32'd8192) >> 14;
      return prod[31] ? (16'd0 - res[15:0]) : res[15:0];
   endfunction

   always_comb begin
      mul_in.info = in_word.info;
      mul_in.prod_x = $signed(in_word.cos_u) * $signed(in_word.cos_v);
      mul_in.prod_y = $signed(in_word.cos_u) * $signed(in_word.sin_v);
      mul_in.pos_z = in_word.sin_u;
   end

   always_comb begin
      out_in = '0;
      out_in.info = mul_ff.info;
      if (mul_ff.info.item_valid) begin
         out_in.pos_x = round_q14(mul_ff.prod_x);
         out_in.pos_y = round_q14(mul_ff.prod_y);
         out_in.pos_z = mul_ff.pos_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en_mul) begin
            mul_valid_ff <= in_valid;
         end
         if (en_out) begin
            out_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_mul) begin
         mul_ff <= mul_in;
      end
      if (en_out) begin
         out_ff <= out_in;
      end
   end

   assign mul_valid = mul_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word = out_ff;

endmodule

@@ bench/tb_uv_sphere_mesh_point.sv @@
// ----------------------------------------------------------------------------
// tb_uv_sphere_mesh_point
// Streams stack/sector grid points into the sphere point generator under
// random valid/ready gaps and several count settings, and checks every
// response word, field by field, against an in-bench model of the sphere.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uv_sphere_mesh_point;

   localparam int PIPE_LATENCY = 4;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int N_PHASES = 7;
   // indexes with no register behind them
   localparam logic [uvsph_pkg::CSR_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
   localparam logic [uvsph_pkg::CSR_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

   typedef struct {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [14:0]        tex_s;
      logic [14:0]        tex_t;
      logic [15:0]        vertex_index;
      logic [15:0]        below_index;
      logic               upper_tri;
      logic               lower_tri;
      logic               item_ok;
      logic [7:0]         src_stack;
      logic [7:0]         src_sector;
   } vertex_type;

   class vertex_board_type;
      int unsigned sectors;
      int unsigned stacks;
      int          errors;
      int          sine_q14 [0:uvsph_pkg::TRIG_TABLE_DEPTH];
      vertex_type  pending_vertices [$];

      function new();
         sectors = 32'(uvsph_pkg::SECTOR_RESET);
         stacks = 32'(uvsph_pkg::STACK_RESET);
         errors = 0;
         build_sine();
      endfunction

      // quarter wave, Q30 Taylor series rounded to Q14
      function void build_sine();
         longint unsigned x;
         longint unsigned term;
         longint unsigned q;
         longint          sum;
         for (int e = 0; e <= uvsph_pkg::TRIG_TABLE_DEPTH; e++) begin
            x = (longint'(e) * uvsph_pkg::HALF_PI_Q30) / uvsph_pkg::TRIG_TABLE_DEPTH;
            term = x;
            sum = x;
            for (int n = 1; n <= 6; n++) begin
               term = (term * x) >> 30;
               term = (term * x) >> 30;
               term = term / ((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
            if (sum < 0) begin
               sum = 0;
            end
            q = ($unsigned(sum) + 64'd32768) >> 16;
            if (q > uvsph_pkg::ONE_Q14) begin
               q = 64'(uvsph_pkg::ONE_Q14);
            end
            sine_q14[e] = int'(q);
         end
      endfunction

      function int sine_of(bit [15:0] p);
         int unsigned idx;
         idx = (int'(p[13:0]) * uvsph_pkg::TRIG_TABLE_DEPTH + 8192) >> 14;
         if (idx > uvsph_pkg::TRIG_TABLE_DEPTH) begin
            idx = uvsph_pkg::TRIG_TABLE_DEPTH;
         end
         case (p[15:14])
            2'd0: return sine_q14[idx];
            2'd1: return sine_q14[uvsph_pkg::TRIG_TABLE_DEPTH - idx];
            2'd2: return -sine_q14[idx];
            default: return -sine_q14[uvsph_pkg::TRIG_TABLE_DEPTH - idx];
         endcase
      endfunction

      // Q14 x Q14, rounded half away from zero back to Q14
      function int scale_q14(int a, int b);
         int          prod;
         int unsigned mag;
         int          res;
         prod = a * b;
         mag = (prod < 0) ? -prod : prod;
         res = (mag + 8192) >> 14;
         return (prod < 0) ? -res : res;
      endfunction

      function int unsigned clamp_count(bit [7:0] v, int unsigned lo);
         if (v < lo) begin
            return lo;
         end
         if (v > uvsph_pkg::MAX_DIVISIONS) begin
            return uvsph_pkg::MAX_DIVISIONS;
         end
         return 32'(v);
      endfunction

      function void write_reg(logic [uvsph_pkg::CSR_IDX_W-1:0] idx, bit [7:0] data);
         if (idx == uvsph_pkg::REG_SECTOR_COUNT) begin
            sectors = clamp_count(data, uvsph_pkg::MIN_SECTORS);
         end else if (idx == uvsph_pkg::REG_STACK_COUNT) begin
            stacks = clamp_count(data, uvsph_pkg::MIN_STACKS);
         end
      endfunction

      function vertex_type sphere_vertex(bit [7:0] i, bit [7:0] j);
         vertex_type  v;
         bit [31:0]   sec_ph;
         bit [31:0]   stk_ph;
         bit [31:0]   k1;
         int          ring;
         v = '{default: 0};
         v.src_stack = i;
         v.src_sector = j;
         if (i > stacks || j > sectors) begin
            return v;
         end
         sec_ph = ((j * 32'd65536 + sectors / 2) / sectors) & 32'hFFFF;
         stk_ph = (32'd16384 - (i * 32'd32768 + stacks / 2) / stacks) & 32'hFFFF;
         ring = sine_of(16'(stk_ph + 32'd16384));
         v.pos_z = 16'(sine_of(16'(stk_ph)));
         v.pos_x = 16'(scale_q14(ring, sine_of(16'(sec_ph + 32'd16384))));
         v.pos_y = 16'(scale_q14(ring, sine_of(16'(sec_ph))));
         v.tex_s = 15'((j * 32'd16384 + sectors / 2) / sectors);
         v.tex_t = 15'((i * 32'd16384 + stacks / 2) / stacks);
         k1 = i * (sectors + 1) + j;
         v.vertex_index = k1[15:0];
         v.below_index = 16'(k1 + sectors + 1);
         v.upper_tri = (j < sectors) && (i < stacks) && (i != 0);
         v.lower_tri = (j < sectors) && (i + 1 < stacks);
         v.item_ok = 1'b1;
         return v;
      endfunction

      function void note_point(bit [7:0] i, bit [7:0] j);
         pending_vertices = {pending_vertices, sphere_vertex(i, j)};
      endfunction

      function int pending();
         return pending_vertices.size();
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task compare_field(string name, int got_v, int want_v, vertex_type w);
         if (got_v != want_v) begin
            report_mismatch($sformatf("%s got %0d expected %0d (stack %0d sector %0d)",
                                      name, got_v, want_v, w.src_stack, w.src_sector));
         end
      endtask

      task check_vertex(vertex_type got);
         vertex_type w;
         if (pending_vertices.size() == 0) begin
            report_mismatch("response word with nothing outstanding");
            return;
         end
         w = pending_vertices.pop_front();
         compare_field("pos_x", int'(got.pos_x), int'(w.pos_x), w);
         compare_field("pos_y", int'(got.pos_y), int'(w.pos_y), w);
         compare_field("pos_z", int'(got.pos_z), int'(w.pos_z), w);
         compare_field("tex_s", int'(got.tex_s), int'(w.tex_s), w);
         compare_field("tex_t", int'(got.tex_t), int'(w.tex_t), w);
         compare_field("vertex_index", int'(got.vertex_index), int'(w.vertex_index), w);
         compare_field("below_index", int'(got.below_index), int'(w.below_index), w);
         compare_field("upper_tri_valid", int'(got.upper_tri), int'(w.upper_tri), w);
         compare_field("lower_tri_valid", int'(got.lower_tri), int'(w.lower_tri), w);
         compare_field("item_valid", int'(got.item_ok), int'(w.item_ok), w);
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_stack_idx = 8'd0;
   logic [7:0]           req_sector_idx = 8'd0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [15:0]   rsp_pos_x;
   logic signed [15:0]   rsp_pos_y;
   logic signed [15:0]   rsp_pos_z;
   logic [14:0]          rsp_tex_s;
   logic [14:0]          rsp_tex_t;
   logic [15:0]          rsp_vertex_index;
   logic [15:0]          rsp_below_index;
   logic                 rsp_upper_tri_valid;
   logic                 rsp_lower_tri_valid;
   logic                 rsp_item_valid;
   logic                 csr_we = 1'b0;
   logic [uvsph_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_wdata = 8'd0;

   bit                   steady = 1'b0;
   vertex_board_type     board;

   uv_sphere_mesh_point uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_stack_idx       (req_stack_idx),
      .req_sector_idx      (req_sector_idx),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pos_x           (rsp_pos_x),
      .rsp_pos_y           (rsp_pos_y),
      .rsp_pos_z           (rsp_pos_z),
      .rsp_tex_s           (rsp_tex_s),
      .rsp_tex_t           (rsp_tex_t),
      .rsp_vertex_index    (rsp_vertex_index),
      .rsp_below_index     (rsp_below_index),
      .rsp_upper_tri_valid (rsp_upper_tri_valid),
      .rsp_lower_tri_valid (rsp_lower_tri_valid),
      .rsp_item_valid      (rsp_item_valid),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 27);
   end

   always @(posedge clock) begin : rsp_monitor
      vertex_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{default: 0};
         got.pos_x = rsp_pos_x;
         got.pos_y = rsp_pos_y;
         got.pos_z = rsp_pos_z;
         got.tex_s = rsp_tex_s;
         got.tex_t = rsp_tex_t;
         got.vertex_index = rsp_vertex_index;
         got.below_index = rsp_below_index;
         got.upper_tri = rsp_upper_tri_valid;
         got.lower_tri = rsp_lower_tri_valid;
         got.item_ok = rsp_item_valid;
         board.check_vertex(got);
      end
   end

   task automatic send_point(bit [7:0] i, bit [7:0] j);
      @(negedge clock);
      req_valid <= 1'b1;
      req_stack_idx <= i;
      req_sector_idx <= j;
      do @(posedge clock); while (!req_ready);
      board.note_point(i, j);
   endtask

   task automatic idle_for(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // drop valid, let every outstanding word come back, then let the pipe settle
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic csr_write(logic [uvsph_pkg::CSR_IDX_W-1:0] idx, bit [7:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      board.write_reg(idx, data);
   endtask

   task automatic csr_done();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly in-range points with the grid edges weighted up, some beyond the counts
   function automatic void pick_point(output bit [7:0] i, output bit [7:0] j);
      int          roll;
      int unsigned s_cnt;
      int unsigned t_cnt;
      s_cnt = board.sectors;
      t_cnt = board.stacks;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         i = 8'($urandom_range(0, 255));
         j = 8'($urandom_range(0, 255));
         if (t_cnt < uvsph_pkg::MAX_DIVISIONS && roll < 5) begin
            i = 8'($urandom_range(t_cnt + 1, 255));
         end else if (s_cnt < uvsph_pkg::MAX_DIVISIONS) begin
            j = 8'($urandom_range(s_cnt + 1, 255));
         end
      end else if (roll < 30) begin
         case ($urandom_range(0, 3))
            0: i = 8'd0;
            1: i = 8'd1;
            2: i = 8'(t_cnt - 1);
            default: i = 8'(t_cnt);
         endcase
         case ($urandom_range(0, 3))
            0: j = 8'd0;
            1: j = 8'd1;
            2: j = 8'(s_cnt - 1);
            default: j = 8'(s_cnt);
         endcase
      end else begin
         i = 8'($urandom_range(0, t_cnt));
         j = 8'($urandom_range(0, s_cnt));
      end
   endfunction

   initial begin : stimulus
      bit [7:0] corner_stack [20] = '{0, 0, 10, 10, 9, 9, 1, 0, 5, 11,
                                      0, 255, 255, 0, 3, 10, 1, 8, 2, 7};
      bit [7:0] corner_sector [20] = '{0, 10, 0, 10, 0, 9, 0, 9, 5, 0,
                                       11, 255, 0, 255, 7, 9, 10, 3, 5, 1};
      // counts below the minimum must clamp up
      bit [7:0] sec_cfg [N_PHASES] = '{3, 255, 0, 17, 255, 2, 64};
      bit [7:0] stk_cfg [N_PHASES] = '{2, 255, 1, 13, 2, 0, 200};
      bit [7:0] si;
      bit [7:0] sj;
      int       gap;
      board = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset counts, grid corners and out-of-range points
      for (int n = 0; n < 20; n++) begin
         send_point(corner_stack[n], corner_sector[n]);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         wait_drained();
         csr_write(uvsph_pkg::REG_SECTOR_COUNT, sec_cfg[p]);
         csr_write(uvsph_pkg::REG_STACK_COUNT, stk_cfg[p]);
         if (p == 3) begin
            csr_write(REG_UNUSED_2, 8'($urandom));
            csr_write(REG_UNUSED_3, 8'($urandom));
         end
         csr_done();
         steady = (p == 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == 120) begin
               steady = 1'b0;
            end
            if (p % 2 == 0 && n == ITEMS_PER_PHASE / 2) begin
               wait_drained();
            end
            gap = 0;
            while (!steady && $urandom_range(0, 99) < 27) begin
               gap++;
            end
            if (gap > 0) begin
               idle_for(gap);
            end
            pick_point(si, sj);
            send_point(si, sj);
         end
      end

      wait_drained();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ uv_sphere_mesh_point.f @@
sv/uvsph_pkg.sv
sv/uvsph_recip.sv
sv/uvsph_front.sv
sv/uvsph_trig.sv
sv/uvsph_scale.sv
sv/uv_sphere_mesh_point.sv
bench/tb_uv_sphere_mesh_point.sv
